/* hw/rtl/ptw_pkg.sv */
// Shared types and constants of the two-level page table walker.
package ptw_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_IDX_SUP_ROOT = 2'd1;
  localparam logic [1:0] CFG_IDX_USR_ROOT = 2'd2;

  // Request types
  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_TABLE_WR  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ROOT  = 3'd1;
  localparam logic [2:0] ST_TABLE = 3'd2;
  localparam logic [2:0] ST_PAGE  = 3'd3;
  localparam logic [2:0] ST_WPROT = 3'd4;

  // Status register bits
  localparam logic [3:0] BIT_NONE  = 4'h0;
  localparam logic [3:0] BIT_ROOT  = 4'h1;
  localparam logic [3:0] BIT_PAGE  = 4'h2;
  localparam logic [3:0] BIT_WPROT = 4'h4;
  localparam logic [3:0] BIT_TABLE = 4'h8;

  // Descriptor bit positions
  localparam int DESC_VALID_BIT = 0;
  localparam int DESC_WPROT_BIT = 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_L1,
    S_L2
  } ptw_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;      // write one zero word of the clearing pass
    logic take_xlate;  // latch a translate word, issue first-level read
    logic take_write;  // write a table word
    logic l2_rd;       // issue second-level read
    logic load_out;    // load the result register
    logic sel_l2;      // result comes from the second-level check
  } ptw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;    // clearing pass writes its last entry
    logic req_is_wr;   // input word is a table write
    logic l1_go;       // first-level descriptor passes, walk on
    logic out_free;    // result register can take a new word
  } ptw_sts_t;

endpackage

/* hw/rtl/ptw_ctrl.sv */
// Walk controller: sequences clearing, table writes and the two-level walk.
module ptw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ptw_pkg::ptw_sts_t sts,
  output ptw_pkg::ptw_cmd_t cmd
);

  ptw_pkg::ptw_state_t state_r;
  ptw_pkg::ptw_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptw_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptw_pkg::S_CLEAR: begin
        if (sts.clr_last) state_nxt = ptw_pkg::S_IDLE;
      end
      ptw_pkg::S_IDLE: begin
        if (in_valid && !sts.req_is_wr) state_nxt = ptw_pkg::S_L1;
      end
      ptw_pkg::S_L1: begin
        if (sts.l1_go) begin
          state_nxt = ptw_pkg::S_L2;
        end else if (sts.out_free) begin
          state_nxt = ptw_pkg::S_IDLE;
        end
      end
      ptw_pkg::S_L2: begin
        if (sts.out_free) state_nxt = ptw_pkg::S_IDLE;
      end
      default: state_nxt = ptw_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ptw_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ptw_pkg::S_IDLE: begin
        in_stall       = 1'b0;
        cmd.take_xlate = in_valid && !sts.req_is_wr;
        cmd.take_write = in_valid && sts.req_is_wr;
      end
      ptw_pkg::S_L1: begin
        cmd.l2_rd    = sts.l1_go;
        cmd.load_out = !sts.l1_go && sts.out_free;
      end
      ptw_pkg::S_L2: begin
        cmd.load_out = sts.out_free;
        cmd.sel_l2   = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/ptw_dp.sv */
// Walk datapath: descriptor memory, configuration, request and result registers.
module ptw_dp #(
  parameter int unsigned TABLE_WORDS = 16384
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_req_type,
  input  logic [31:0]       in_address,
  input  logic              in_write_access,
  input  logic              in_supervisor_mode,
  input  logic [31:0]       in_table_word,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [31:0]       out_physical_address,
  output logic [2:0]        out_status,
  output logic [3:0]        out_mmu_status_bits,
  input  ptw_pkg::ptw_cmd_t cmd,
  output ptw_pkg::ptw_sts_t sts
);

  localparam int          AW       = $clog2(TABLE_WORDS);
  localparam logic [29:0] TW_LIMIT = 30'(TABLE_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_WORDS - 1);

  logic [31:0] mem [TABLE_WORDS];

  logic        enable_r;
  logic [31:0] sup_root_r;
  logic [31:0] usr_root_r;

  logic [AW-1:0] clr_cnt_r;
  logic [31:0]   rd_data_r;
  logic [31:0]   addr_r;
  logic          wr_r;
  logic          sup_r;
  logic          l1_in_r;
  logic          l2_in_r;

  logic          out_valid_r;
  logic [31:0]   out_pa_r;
  logic [2:0]    out_st_r;
  logic [3:0]    out_bits_r;

  logic [31:0] root_in;
  logic [29:0] l1_idx_in;
  logic        l1_in_nxt;
  logic [29:0] l2_idx;
  logic        l2_in_nxt;
  logic [29:0] w_idx;
  logic        w_in;
  logic [31:0] root_cur;
  logic        root_zero;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  logic [31:0] res_pa;
  logic [2:0]  res_st;
  logic [3:0]  res_bits;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      sup_root_r <= '0;
      usr_root_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptw_pkg::CFG_IDX_ENABLE:   enable_r   <= cfg_wdata[0];
        ptw_pkg::CFG_IDX_SUP_ROOT: sup_root_r <= cfg_wdata;
        ptw_pkg::CFG_IDX_USR_ROOT: usr_root_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Word indexes: root frame and index bits never carry into each other
  assign root_in   = in_supervisor_mode ? sup_root_r : usr_root_r;
  assign l1_idx_in = {root_in[31:12], in_address[31:22]};
  assign l1_in_nxt = l1_idx_in < TW_LIMIT;
  assign l2_idx    = {rd_data_r[31:12], addr_r[21:12]};
  assign l2_in_nxt = l2_idx < TW_LIMIT;
  assign w_idx     = in_address[31:2];
  assign w_in      = w_idx < TW_LIMIT;
  assign root_cur  = sup_r ? sup_root_r : usr_root_r;
  assign root_zero = root_cur[31:12] == 20'd0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_r;
    mem_wd = '0;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd.take_write && w_in) begin
      mem_we = 1'b1;
      mem_wa = w_idx[AW-1:0];
      mem_wd = in_table_word;
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = l1_idx_in[AW-1:0];
    if (cmd.take_xlate && l1_in_nxt) begin
      mem_re = 1'b1;
    end else if (cmd.l2_rd && l2_in_nxt) begin
      mem_re = 1'b1;
      mem_ra = l2_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_xlate) begin
      addr_r  <= in_address;
      wr_r    <= in_write_access;
      sup_r   <= in_supervisor_mode;
      l1_in_r <= l1_in_nxt;
    end
    if (cmd.l2_rd) l2_in_r <= l2_in_nxt;
  end

  always_comb begin
    res_pa   = '0;
    res_st   = ptw_pkg::ST_OK;
    res_bits = ptw_pkg::BIT_NONE;
    if (!cmd.sel_l2) begin
      if (!enable_r) begin
        res_pa = addr_r;
      end else if (root_zero) begin
        res_st   = ptw_pkg::ST_ROOT;
        res_bits = ptw_pkg::BIT_ROOT;
      end else if (!l1_in_r) begin
        res_st   = ptw_pkg::ST_TABLE;
        res_bits = ptw_pkg::BIT_TABLE;
      end else begin
        res_st   = ptw_pkg::ST_ROOT;
        res_bits = ptw_pkg::BIT_ROOT;
      end
    end else begin
      if (!l2_in_r) begin
        res_st   = ptw_pkg::ST_TABLE;
        res_bits = ptw_pkg::BIT_TABLE;
      end else if (!rd_data_r[ptw_pkg::DESC_VALID_BIT]) begin
        res_st   = ptw_pkg::ST_PAGE;
        res_bits = ptw_pkg::BIT_PAGE;
      end else if (wr_r && rd_data_r[ptw_pkg::DESC_WPROT_BIT]) begin
        res_st   = ptw_pkg::ST_WPROT;
        res_bits = ptw_pkg::BIT_WPROT;
      end else begin
        res_pa = {rd_data_r[31:12], addr_r[11:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pa_r   <= res_pa;
      out_st_r   <= res_st;
      out_bits_r <= res_bits;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_status           = out_st_r;
  assign out_mmu_status_bits  = out_bits_r;

  assign sts.clr_last  = clr_cnt_r == CLR_LAST;
  assign sts.req_is_wr = in_req_type == ptw_pkg::REQ_TABLE_WR;
  assign sts.l1_go     = enable_r && !root_zero && l1_in_r
                         && rd_data_r[ptw_pkg::DESC_VALID_BIT];
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

/* hw/rtl/two_level_page_table_walker_core.sv */
// Top level of the two-level page table walker.
// A translate word reads its first-level descriptor; S_L1 loads the result on pass-through
// or first-level fault, else reads the second-level descriptor (full walk) and S_L2 loads it.
// Result loads wait while the output stalls; new words are taken only in S_IDLE, which a table
// write never leaves. Reset: synchronous rst_n clears control and config, then a clearing pass
// zeroes the memory with in_stall high; config writes are taken throughout.
module two_level_page_table_walker_core #(
  parameter int unsigned TABLE_WORDS = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input word channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_address,
  input  logic        in_write_access,
  input  logic        in_supervisor_mode,
  input  logic [31:0] in_table_word,
  // result word channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_physical_address,
  output logic [2:0]  out_status,
  output logic [3:0]  out_mmu_status_bits
);

  // Commands flow down to the datapath, status flows back up.
  ptw_pkg::ptw_cmd_t cmd;
  ptw_pkg::ptw_sts_t sts;

  // The controller owns the input handshake: it takes a word only while idle,
  // so a walk never overlaps a table write or another walk.
  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the descriptor memory, the registered read word, the
  // latched request and the result register that decouples the output side.
  ptw_dp #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_req_type          (in_req_type),
    .in_address           (in_address),
    .in_write_access      (in_write_access),
    .in_supervisor_mode   (in_supervisor_mode),
    .in_table_word        (in_table_word),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_physical_address (out_physical_address),
    .out_status           (out_status),
    .out_mmu_status_bits  (out_mmu_status_bits),
    .cmd                  (cmd),
    .sts                  (sts)
  );

endmodule

/* hw/rtl/ptw_checker.sv */
// Port-level checker of the page table walker, bound to the top level.
module ptw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_physical_address,
  input logic [2:0]  out_status,
  input logic [3:0]  out_mmu_status_bits
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_physical_address)
      && $stable(out_status) && $stable(out_mmu_status_bits))
    else $error("stalled result word changed or dropped");

  // Drop the address on any fault.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ptw_pkg::ST_OK |-> out_physical_address == 32'd0)
    else $error("faulted result carries an address");

  // Status code and status bits agree.
  a_bits_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_status == ptw_pkg::ST_OK    && out_mmu_status_bits == ptw_pkg::BIT_NONE)  ||
      (out_status == ptw_pkg::ST_ROOT  && out_mmu_status_bits == ptw_pkg::BIT_ROOT)  ||
      (out_status == ptw_pkg::ST_TABLE && out_mmu_status_bits == ptw_pkg::BIT_TABLE) ||
      (out_status == ptw_pkg::ST_PAGE  && out_mmu_status_bits == ptw_pkg::BIT_PAGE)  ||
      (out_status == ptw_pkg::ST_WPROT && out_mmu_status_bits == ptw_pkg::BIT_WPROT))
    else $error("status code and status bits disagree");

  // Hold off input while the clearing pass starts.
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during the clearing pass");

endmodule

bind two_level_page_table_walker_core ptw_checker u_ptw_checker (.*);
